>>> rtl/mlfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfd_pkg
// shared types and constants of the magic/length frame deframer
// ----------------------------------------------------------------------------
package mlfd_pkg;

  localparam int DATA_W   = 8;
  localparam int EVENT_W  = 16;
  localparam int LENGTH_W = 32;
  localparam int INDEX_W  = 31;
  localparam int KIND_W   = 2;
  localparam int CFG_W    = 32;

  localparam int HDR_MAGIC_BYTES = 4;
  localparam int HDR_EVENT_BYTES = 2;
  localparam int HDR_LEN_BYTES   = 4;
  localparam int HDR_TOTAL       = HDR_MAGIC_BYTES + HDR_EVENT_BYTES + HDR_LEN_BYTES;
  localparam int HDR_CNT_W       = 4;

  localparam logic [CFG_W-1:0]   MAGIC_RESET   = 32'h4642_4542;
  localparam logic [INDEX_W-1:0] MAX_LEN_RESET = 31'd65536;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic CFG_MAGIC   = 1'b0;
  localparam logic CFG_MAX_LEN = 1'b1;

  localparam logic [KIND_W-1:0] KIND_DATA       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BAD_MAGIC  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD_LENGTH = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DROPPED    = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic [DATA_W-1:0]          payload_byte;
    logic [EVENT_W-1:0]         event_id;
    logic signed [LENGTH_W-1:0] frame_length;
    logic [INDEX_W-1:0]         byte_index;
    logic                       last;
  } res_t;

endpackage

>>> rtl/magic_length_frame_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magic_length_frame_deframer_unit
// magic/event/length frame deframer for one connection byte stream
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with in_data_byte and in_restart; one
//   stream byte or a restart per transaction
// result channel: out_valid / out_stall with kind, payload byte, event id,
//   frame length, byte index and last flag; zero or one result per input
// config: cfg_wr_en, cfg_index (0 magic word, 1 max length), cfg_wdata;
//   write only while the block is idle
// throughput: one input transaction per cycle while in_stall is low, set by the
//   header/payload state update in the front classifier
// result path: a result is written into the queue, then loaded into the output
//   register, and only then presented; it is held there for longer while
//   out_stall is high
// out_stall: results collect in a QUEUE_DEPTH entry queue; in_stall rises
//   once that queue is full, and no result is lost or repeated
// reset: synchronous on rst_n low; parser returns to header collection,
//   header fields clear, registers go to their defaults, queue empties
// ----------------------------------------------------------------------------
module magic_length_frame_deframer_unit import mlfd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [DATA_W-1:0]          in_data_byte,
  input  logic                       in_restart,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [KIND_W-1:0]          out_kind,
  output logic [DATA_W-1:0]          out_payload_byte,
  output logic [EVENT_W-1:0]         out_event_id,
  output logic signed [LENGTH_W-1:0] out_frame_length,
  output logic [INDEX_W-1:0]         out_byte_index,
  output logic                       out_last,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata
);

  logic push;
  logic pop;
  logic full;
  logic empty;
  res_t push_data;
  res_t pop_data;

  mlfd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_restart   (in_restart),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .push         (push),
    .push_data    (push_data),
    .full         (full)
  );

  mlfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  mlfd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .empty            (empty),
    .pop_data         (pop_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_event_id     (out_event_id),
    .out_frame_length (out_frame_length),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last)
  );

endmodule

>>> rtl/mlfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfd_front
// accepts stream bytes, collects and checks the header, classifies each byte
// ----------------------------------------------------------------------------
module mlfd_front import mlfd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] in_data_byte,
  input  logic              in_restart,
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output logic              push,
  output res_t              push_data,
  input  logic              full
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_STOPPED = 2'd2;

  localparam logic [HDR_CNT_W-1:0] HDR_LAST_CNT = HDR_CNT_W'(HDR_TOTAL);
  localparam logic [HDR_CNT_W-1:0] EVT_POS      = HDR_CNT_W'(HDR_MAGIC_BYTES);
  localparam logic [HDR_CNT_W-1:0] LEN_POS      = HDR_CNT_W'(HDR_MAGIC_BYTES + HDR_EVENT_BYTES);

  logic [CFG_W-1:0]    magic_word_r;
  logic [INDEX_W-1:0]  max_length_r;

  logic [1:0]          phase_r, phase_nxt;
  logic [HDR_CNT_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]         magic_r, magic_nxt;
  logic [EVENT_W-1:0]  event_r, event_nxt;
  logic [LENGTH_W-1:0] length_r, length_nxt;
  logic [INDEX_W-1:0]  pay_cnt_r, pay_cnt_nxt;

  logic                acc;
  logic [HDR_CNT_W-1:0] hdr_cnt_inc;
  logic [HDR_CNT_W-1:0] len_off;
  logic [LENGTH_W-1:0] idx_inc;
  logic                is_last;
  logic                bad_len;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    magic_nxt   = magic_r;
    event_nxt   = event_r;
    length_nxt  = length_r;
    pay_cnt_nxt = pay_cnt_r;
    push        = 1'b0;
    hdr_cnt_inc = hdr_cnt_r + 1'b1;
    len_off     = hdr_cnt_r - LEN_POS;
    idx_inc     = {1'b0, pay_cnt_r} + 1'b1;
    is_last     = idx_inc >= length_r;
    bad_len     = 1'b0;
    push_data.kind         = KIND_DROPPED;
    push_data.payload_byte = '0;
    push_data.byte_index   = '0;
    push_data.last         = 1'b0;

    if (acc) begin
      if (in_restart) begin
        phase_nxt   = PH_HEADER;
        hdr_cnt_nxt = '0;
        pay_cnt_nxt = '0;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            if (hdr_cnt_r < EVT_POS) begin
              magic_nxt = {magic_r[23:0], in_data_byte};
            end else if (hdr_cnt_r < LEN_POS) begin
              event_nxt[{hdr_cnt_r[0], 3'b000} +: 8] = in_data_byte;
            end else begin
              length_nxt[{len_off[1:0], 3'b000} +: 8] = in_data_byte;
            end
            hdr_cnt_nxt = hdr_cnt_inc;
            bad_len = length_nxt[LENGTH_W-1] || (length_nxt == '0) ||
                      (length_nxt[INDEX_W-1:0] > max_length_r);
            if (hdr_cnt_inc >= HDR_LAST_CNT) begin
              hdr_cnt_nxt = '0;
              if (magic_nxt != magic_word_r) begin
                phase_nxt      = PH_STOPPED;
                push           = 1'b1;
                push_data.kind = KIND_BAD_MAGIC;
              end else if (bad_len) begin
                phase_nxt      = PH_STOPPED;
                push           = 1'b1;
                push_data.kind = KIND_BAD_LENGTH;
              end else begin
                phase_nxt   = PH_PAYLOAD;
                pay_cnt_nxt = '0;
              end
            end
          end
          PH_PAYLOAD: begin
            push                   = 1'b1;
            push_data.kind         = KIND_DATA;
            push_data.payload_byte = in_data_byte;
            push_data.byte_index   = pay_cnt_r;
            push_data.last         = is_last;
            pay_cnt_nxt            = idx_inc[INDEX_W-1:0];
            if (is_last) begin
              phase_nxt = PH_STOPPED;
            end
          end
          default: begin
            push = 1'b1;
          end
        endcase
      end
    end

    push_data.event_id     = event_nxt;
    push_data.frame_length = length_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_word_r <= MAGIC_RESET;
      max_length_r <= MAX_LEN_RESET;
      phase_r      <= PH_HEADER;
      hdr_cnt_r    <= '0;
      magic_r      <= '0;
      event_r      <= '0;
      length_r     <= '0;
      pay_cnt_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_MAGIC:   magic_word_r <= cfg_wdata;
          CFG_MAX_LEN: max_length_r <= cfg_wdata[INDEX_W-1:0];
          default:     magic_word_r <= magic_word_r;
        endcase
      end
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      magic_r   <= magic_nxt;
      event_r   <= event_nxt;
      length_r  <= length_nxt;
      pay_cnt_r <= pay_cnt_nxt;
    end
  end

  a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_cnt_r < HDR_LAST_CNT)
    else $error("header count out of range");

  a_payload_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (!length_r[LENGTH_W-1] && length_r != '0))
    else $error("payload phase with a bad frame length");

  a_payload_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> ({1'b0, pay_cnt_r} < length_r))
    else $error("payload index past frame length");

  a_no_push_on_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_restart) |-> !push)
    else $error("restart produced a transaction");

endmodule

>>> rtl/mlfd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfd_queue
// small result queue between the classifier and the output stage
// ----------------------------------------------------------------------------
module mlfd_queue import mlfd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic full,
  input  logic pop,
  output res_t pop_data,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("pop from empty queue");

endmodule

>>> rtl/mlfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfd_back
// output register stage driving the result channel
// ----------------------------------------------------------------------------
module mlfd_back import mlfd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       empty,
  input  res_t                       pop_data,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [KIND_W-1:0]          out_kind,
  output logic [DATA_W-1:0]          out_payload_byte,
  output logic [EVENT_W-1:0]         out_event_id,
  output logic signed [LENGTH_W-1:0] out_frame_length,
  output logic [INDEX_W-1:0]         out_byte_index,
  output logic                       out_last
);

  logic out_valid_r;
  res_t out_data_r;

  assign pop = !empty && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= pop_data;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_data_r.kind;
  assign out_payload_byte = out_data_r.payload_byte;
  assign out_event_id     = out_data_r.event_id;
  assign out_frame_length = out_data_r.frame_length;
  assign out_byte_index   = out_data_r.byte_index;
  assign out_last         = out_data_r.last;

  a_fill_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r)
    else $error("output register not loaded after pop");

  a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && empty) |=> !out_valid_r)
    else $error("output transaction repeated");

  a_data_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind != KIND_DATA) |->
      (out_data_r.payload_byte == '0 && out_data_r.byte_index == '0 && !out_data_r.last))
    else $error("non-data result carries payload fields");

endmodule

>>> dv/mlfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfd_checker
// Watches the input, result and register ports of the deframer. Every
// accepted input transaction runs through an independent model of the
// header/payload parser, and the model's results are kept in order. Each
// accepted result is compared with the oldest one still waiting.
// ----------------------------------------------------------------------------
module mlfd_checker import mlfd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [DATA_W-1:0]          in_data_byte,
  input  logic                       in_restart,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [KIND_W-1:0]          out_kind,
  input  logic [DATA_W-1:0]          out_payload_byte,
  input  logic [EVENT_W-1:0]         out_event_id,
  input  logic signed [LENGTH_W-1:0] out_frame_length,
  input  logic [INDEX_W-1:0]         out_byte_index,
  input  logic                       out_last,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_index,
  input  logic [CFG_W-1:0]           cfg_wdata,
  output int                         mismatch_count,
  output int                         pending_count,
  output int                         checked_count
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_STOPPED = 2'd2
  } parse_phase_t;

  parse_phase_t         phase;
  logic [HDR_CNT_W-1:0] hdr_count;
  logic [31:0]          hdr_magic;
  logic [EVENT_W-1:0]   hdr_event;
  logic [LENGTH_W-1:0]  hdr_length;
  logic [INDEX_W-1:0]   pay_count;
  logic [CFG_W-1:0]     want_magic;
  logic [INDEX_W-1:0]   len_limit;

  res_t expected_results[$];

  function automatic res_t frame_result(input logic [KIND_W-1:0] kind,
                                        input logic [DATA_W-1:0] b,
                                        input logic [INDEX_W-1:0] idx,
                                        input logic last);
    res_t r;
    r.kind         = kind;
    r.payload_byte = b;
    r.event_id     = hdr_event;
    r.frame_length = hdr_length;
    r.byte_index   = idx;
    r.last         = last;
    return r;
  endfunction

  task automatic deframe_step(input logic [DATA_W-1:0] b, input logic rs);
    int   pos;
    logic last;
    if (rs) begin
      phase     = PH_HEADER;
      hdr_count = '0;
      pay_count = '0;
    end else if (phase == PH_HEADER) begin
      pos = hdr_count;
      if (pos < HDR_MAGIC_BYTES) begin
        hdr_magic = {hdr_magic[23:0], b};
      end else if (pos < HDR_MAGIC_BYTES + HDR_EVENT_BYTES) begin
        hdr_event[8*(pos-HDR_MAGIC_BYTES) +: 8] = b;
      end else begin
        hdr_length[8*(pos-HDR_MAGIC_BYTES-HDR_EVENT_BYTES) +: 8] = b;
      end
      if (pos + 1 < HDR_TOTAL) begin
        hdr_count = hdr_count + 1'b1;
      end else begin
        hdr_count = '0;
        if (hdr_magic != want_magic) begin
          phase = PH_STOPPED;
          expected_results.push_back(frame_result(KIND_BAD_MAGIC, '0, '0, 1'b0));
        end else if (hdr_length[31] || hdr_length == 0 || hdr_length[30:0] > len_limit) begin
          phase = PH_STOPPED;
          expected_results.push_back(frame_result(KIND_BAD_LENGTH, '0, '0, 1'b0));
        end else begin
          phase     = PH_PAYLOAD;
          pay_count = '0;
        end
      end
    end else if (phase == PH_PAYLOAD) begin
      last = ({1'b0, pay_count} + 32'd1) >= hdr_length;
      expected_results.push_back(frame_result(KIND_DATA, b, pay_count, last));
      pay_count = pay_count + 1'b1;
      if (last) phase = PH_STOPPED;
    end else begin
      expected_results.push_back(frame_result(KIND_DROPPED, '0, '0, 1'b0));
    end
  endtask

  task automatic note_mismatch(input string what, input res_t want, input res_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: expected kind %0d byte %02h event %04h length %0d index %0d last %0d",
               what, want.kind, want.payload_byte, want.event_id, want.frame_length,
               want.byte_index, want.last);
      $display("  actual   kind %0d byte %02h event %04h length %0d index %0d last %0d",
               got.kind, got.payload_byte, got.event_id, got.frame_length,
               got.byte_index, got.last);
    end
  endtask

  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    if (!rst_n) begin
      phase      = PH_HEADER;
      hdr_count  = '0;
      hdr_magic  = '0;
      hdr_event  = '0;
      hdr_length = '0;
      pay_count  = '0;
      want_magic = MAGIC_RESET;
      len_limit  = MAX_LEN_RESET;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.kind         = out_kind;
        got.payload_byte = out_payload_byte;
        got.event_id     = out_event_id;
        got.frame_length = out_frame_length;
        got.byte_index   = out_byte_index;
        got.last         = out_last;
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = expected_results.pop_front();
          checked_count++;
          if (got !== want) note_mismatch("result mismatch", want, got);
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == CFG_MAGIC) want_magic = cfg_wdata;
        else len_limit = cfg_wdata[INDEX_W-1:0];
      end
      if (in_valid && !in_stall) deframe_step(in_data_byte, in_restart);
    end
    pending_count = expected_results.size();
  end

endmodule

>>> dv/tb_magic_length_frame_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_magic_length_frame_deframer_unit
// Sends header/payload byte streams to the deframer under several magic and
// maximum-length settings: good frames, bad magic, bad and negative lengths,
// cut-short headers and frames, dropped bytes and restarts. Both handshakes
// idle at random. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_magic_length_frame_deframer_unit;
  import mlfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [DATA_W-1:0]          in_data_byte;
  logic                       in_restart;
  logic                       out_valid;
  logic                       out_stall;
  logic [KIND_W-1:0]          out_kind;
  logic [DATA_W-1:0]          out_payload_byte;
  logic [EVENT_W-1:0]         out_event_id;
  logic signed [LENGTH_W-1:0] out_frame_length;
  logic [INDEX_W-1:0]         out_byte_index;
  logic                       out_last;
  logic                       cfg_wr_en;
  logic                       cfg_index;
  logic [CFG_W-1:0]           cfg_wdata;

  int mismatch_count;
  int pending_count;
  int checked_count;

  logic [CFG_W-1:0]   cur_magic;
  logic [INDEX_W-1:0] cur_max;
  int                 n_sent;
  int                 n_settings;
  int                 quiet_cycles;
  bit                 tx_quiet;
  bit                 rx_quiet;
  bit                 rx_hold_req;

  magic_length_frame_deframer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_event_id     (out_event_id),
    .out_frame_length (out_frame_length),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  mlfd_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_event_id     (out_event_id),
    .out_frame_length (out_frame_length),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatch_count),
    .pending_count    (pending_count),
    .checked_count    (checked_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // one input transaction, entered and left at a falling edge
  task automatic send_item(input logic [DATA_W-1:0] b, input logic rs);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 63) == 0) tx_quiet = !tx_quiet;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_restart   <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic send_header(input logic [31:0] m, input logic [15:0] ev,
                             input logic [31:0] len);
    for (int i = 0; i < HDR_MAGIC_BYTES; i++) send_item(m[8*(3-i) +: 8], 1'b0);
    for (int i = 0; i < HDR_EVENT_BYTES; i++) send_item(ev[8*i +: 8], 1'b0);
    for (int i = 0; i < HDR_LEN_BYTES; i++) send_item(len[8*i +: 8], 1'b0);
  endtask

  // up to three more bytes, then a restart back to header collection
  task automatic send_tail();
    int n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) send_item(DATA_W'($urandom), 1'b0);
    send_item(DATA_W'($urandom), 1'b1);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_limits(input logic [CFG_W-1:0] m, input logic [INDEX_W-1:0] mx);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MAGIC;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_index <= CFG_MAX_LEN;
    cfg_wdata <= {1'b0, mx};
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_magic = m;
    cur_max   = mx;
    n_settings++;
  endtask

  // length exactly at the limit, then one above it
  task automatic probe_limits();
    send_header(cur_magic, EVENT_W'($urandom), {1'b0, cur_max});
    send_item(DATA_W'($urandom), 1'b0);
    send_item(DATA_W'($urandom), 1'b0);
    send_item(DATA_W'($urandom), 1'b1);
    send_header(cur_magic, EVENT_W'($urandom), {1'b0, cur_max} + 32'd1);
    send_item(DATA_W'($urandom), 1'b0);
    send_item(DATA_W'($urandom), 1'b1);
  endtask

  task automatic random_frames(input int target);
    int          start;
    int          pick;
    int          lim;
    int          n;
    logic [31:0] len;
    logic [31:0] flip;
    start = n_sent;
    lim   = (cur_max < 24) ? int'(cur_max) : 24;
    while (n_sent - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if (cur_max == 0) len = 32'd1;
        else if ($urandom_range(0, 19) == 0) len = {1'b0, cur_max};
        else len = $urandom_range(1, lim);
        send_header(cur_magic, EVENT_W'($urandom), len);
        n = (len > 24) ? $urandom_range(1, 4) : int'(len);
        if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
        for (int i = 0; i < n; i++) send_item(DATA_W'($urandom), 1'b0);
        send_tail();
      end else if (pick < 75) begin
        case ($urandom_range(0, 3))
          0:       len = 32'd0;
          1:       len = $urandom | 32'h8000_0000;
          2:       len = {1'b0, cur_max} + 32'd1;
          default: len = $urandom;
        endcase
        send_header(cur_magic, EVENT_W'($urandom), len);
        send_tail();
      end else if (pick < 85) begin
        flip = $urandom;
        if (flip == 0) flip = 32'h1;
        send_header(cur_magic ^ flip, EVENT_W'($urandom), $urandom);
        send_tail();
      end else if (pick < 93) begin
        n = $urandom_range(1, HDR_TOTAL - 1);
        for (int i = 0; i < n; i++) send_item(DATA_W'($urandom), 1'b0);
        send_item(DATA_W'($urandom), 1'b1);
      end else begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) send_item(DATA_W'($urandom), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  // result side: random stall per transaction, one long hold on request
  initial begin : result_sink
    int gap;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end
      gap = rx_quiet ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 63) == 0) rx_quiet = !rx_quiet;
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_restart   = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = CFG_MAGIC;
    cfg_wdata    = '0;
    rst_n        = 1'b0;
    cur_magic    = MAGIC_RESET;
    cur_max      = MAX_LEN_RESET;
    n_settings   = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: restart at start, one-byte frame, dropped byte, bad magic
    send_item(8'hFF, 1'b1);
    send_header(cur_magic, 16'hFFFF, 32'd1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h5A, 1'b1);
    send_header(32'h0000_0000, 16'h0000, 32'h8000_0000);
    send_item(8'hA5, 1'b0);
    send_item(8'h00, 1'b1);
    wait_results_drained();
    probe_limits();
    random_frames(80);

    wait_results_drained();
    program_limits(32'h0000_0000, 31'd1);
    probe_limits();
    random_frames(80);

    wait_results_drained();
    program_limits(32'hFFFF_FFFF, 31'h7FFF_FFFF);
    probe_limits();
    random_frames(80);

    wait_results_drained();
    program_limits($urandom, 31'd0);
    probe_limits();
    random_frames(80);

    wait_results_drained();
    program_limits($urandom, INDEX_W'($urandom_range(1, 40)));
    rx_hold_req = 1'b1;
    probe_limits();
    random_frames(90);

    wait_results_drained();
    program_limits($urandom, INDEX_W'($urandom_range(1, 300)));
    probe_limits();
    random_frames(80);

    wait_results_drained();
    repeat (20) @(posedge clk);
    $display("summary: %0d input transactions under %0d register settings, %0d results checked",
             n_sent, n_settings, checked_count);
    $display("summary: good, cut-short and over-long frames, bad magic, bad lengths, restarts");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
